>>> hdl/nttcr_pkg.sv
package nttcr_pkg;

    // Sequencer states of the renderer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } t_state;

    // Widths of the binary value and of its packed BCD form.
    localparam int BIN_W      = 64;
    localparam int BCD_W      = 80;
    localparam int WORK_W     = BIN_W + BCD_W;
    localparam int ADDR_W     = 11;
    localparam int HEX_DIGITS = 16;
    localparam int DEC_DIGITS = 20;
    localparam int CNT_W      = 5;
    localparam int STEP_W     = 6;

    // Rendering mode carried in the input tuser bit.
    localparam logic KIND_HEX = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    // Attribute byte after reset.
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // ASCII code of each digit value.
    localparam logic [7:0] DIGIT_ASCII [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

endpackage

>>> hdl/number_to_text_cell_renderer_top.sv
// Renders one unsigned 64-bit number as a run of text-mode cell writes, one
// transaction per digit, starting at the given row and column; the column wraps
// to the next row and the row clamps at the bottom row. Hexadecimal mode
// (tuser = 0) gives sixteen upper-case digits; decimal mode (tuser = 1) gives
// the digits without leading zeros after the 64 shift-and-adjust steps of the
// shared double-dabble register, then scans the 20 BCD digit positions one by
// one. An output transaction held by tready stalls the writing of digits. The
// input is not ready while a number is being rendered.
module number_to_text_cell_renderer_top #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: cell attribute byte.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,  // start_row[4:0], start_col[11:5], value[75:12], zero
    input  logic        i_s_tuser,  // kind[0]
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // cell_address[10:0], cell_word[26:11], zero
    output logic        o_m_tlast   // last
);

    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int PROD_W = (ROW_W + 9 > nttcr_pkg::ADDR_W) ? ROW_W + 9 : nttcr_pkg::ADDR_W;
    localparam int W      = nttcr_pkg::WORK_W;

    nttcr_pkg::t_state r_state, n_state;

    logic [7:0]                   r_attr;
    logic                         r_kind;
    logic                         r_seen;
    logic [W-1:0]                 r_work;
    logic [nttcr_pkg::CNT_W-1:0]  r_cnt;
    logic [nttcr_pkg::STEP_W-1:0] r_step;
    logic [ROW_W-1:0]             r_row;
    logic [COL_W-1:0]             r_col;
    logic                         r_out_valid;
    logic [nttcr_pkg::ADDR_W-1:0] r_out_addr;
    logic [15:0]                  r_out_word;
    logic                         r_out_last;

    logic [4:0]                   w_in_row;
    logic [6:0]                   w_in_col;
    logic [nttcr_pkg::BIN_W-1:0]  w_in_value;
    logic                         w_in_acc;
    logic                         w_col_wrap;
    logic [6:0]                   w_row_inc;
    logic [6:0]                   w_row_start;
    logic [W-1:0]                 w_dabble;
    logic [3:0]                   w_nib;
    logic                         w_skip;
    logic                         w_slot;
    logic                         w_adv;
    logic                         w_write;
    logic [PROD_W-1:0]            w_addr_full;

    // Input field unpacking and the start position fix-up.
    assign w_in_row    = i_s_tdata[4:0];
    assign w_in_col    = i_s_tdata[11:5];
    assign w_in_value  = i_s_tdata[75:12];
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_col_wrap  = 9'(w_in_col) >= 9'(SCREEN_COLUMNS);
    assign w_row_inc   = 7'(w_in_row) + (w_col_wrap ? 7'd1 : 7'd0);
    assign w_row_start = (w_row_inc >= 7'(SCREEN_ROWS)) ? 7'(SCREEN_ROWS - 1) : w_row_inc;

    // One double-dabble step: adjust every BCD digit, then shift the whole word.
    always_comb begin
        logic [W-1:0] v_adj;
        v_adj = r_work;
        for (int i = 0; i < nttcr_pkg::DEC_DIGITS; i++) begin
            if (v_adj[nttcr_pkg::BIN_W + 4*i +: 4] >= 4'd5) begin
                v_adj[nttcr_pkg::BIN_W + 4*i +: 4] = v_adj[nttcr_pkg::BIN_W + 4*i +: 4] + 4'd3;
            end
        end
        w_dabble = {v_adj[W-2:0], 1'b0};
    end

    // Digit emission control: the top nibble of the work register is the next digit.
    assign w_nib   = r_work[W-1 -: 4];
    assign w_skip  = (r_kind == nttcr_pkg::KIND_DEC) && !r_seen && (w_nib == 4'd0)
                     && (r_cnt != 5'd1);
    assign w_slot  = !r_out_valid || i_m_tready;
    assign w_adv   = (r_state == nttcr_pkg::ST_EMIT) && (w_skip || w_slot);
    assign w_write = (r_state == nttcr_pkg::ST_EMIT) && w_slot && !w_skip;

    // Cell address of the current position.
    assign w_addr_full = PROD_W'(r_row) * PROD_W'(SCREEN_COLUMNS) + PROD_W'(r_col);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nttcr_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_s_tuser == nttcr_pkg::KIND_DEC) ? nttcr_pkg::ST_CONVERT
                                                                  : nttcr_pkg::ST_EMIT;
                end
            end
            nttcr_pkg::ST_CONVERT: begin
                if (r_step == '1) begin
                    n_state = nttcr_pkg::ST_EMIT;
                end
            end
            nttcr_pkg::ST_EMIT: begin
                if (w_adv && r_cnt == 5'd1) begin
                    n_state = nttcr_pkg::ST_IDLE;
                end
            end
            default: n_state = nttcr_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_s_tready  = (r_state == nttcr_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
        o_m_tvalid  = r_out_valid;
        o_m_tdata   = {5'd0, r_out_word, r_out_addr};
        o_m_tlast   = r_out_last;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nttcr_pkg::ST_IDLE;
            r_attr      <= nttcr_pkg::ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (w_write) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Work register, counters, position and output payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_s_tuser;
            r_seen <= 1'b0;
            r_step <= '0;
            r_row  <= ROW_W'(w_row_start);
            r_col  <= w_col_wrap ? '0 : COL_W'(w_in_col);
            if (i_s_tuser == nttcr_pkg::KIND_DEC) begin
                r_work <= {{nttcr_pkg::BCD_W{1'b0}}, w_in_value};
                r_cnt  <= nttcr_pkg::CNT_W'(nttcr_pkg::DEC_DIGITS);
            end else begin
                r_work <= {w_in_value, {nttcr_pkg::BCD_W{1'b0}}};
                r_cnt  <= nttcr_pkg::CNT_W'(nttcr_pkg::HEX_DIGITS);
            end
        end else if (r_state == nttcr_pkg::ST_CONVERT) begin
            r_work <= w_dabble;
            r_step <= r_step + 1'b1;
        end else if (w_adv) begin
            r_work <= {r_work[W-5:0], 4'd0};
            r_cnt  <= r_cnt - 1'b1;
        end

        // A written digit moves the cursor; the row sticks at the bottom.
        if (w_write) begin
            r_seen     <= 1'b1;
            r_out_addr <= w_addr_full[nttcr_pkg::ADDR_W-1:0];
            r_out_word <= {r_attr, nttcr_pkg::DIGIT_ASCII[w_nib]};
            r_out_last <= (r_cnt == 5'd1);
            if (9'(r_col) == 9'(SCREEN_COLUMNS - 1)) begin
                r_col <= '0;
                if (7'(r_row) != 7'(SCREEN_ROWS - 1)) begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

>>> hdl/nttcr_checker.sv
module nttcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tlast
);

    logic [7:0] w_char;
    assign w_char = o_m_tdata[18:11];

    // A held output transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output transaction changed while stalled");

    // Once a number is taken the block is busy rendering it.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after an accepted number");

    // Every cell carries a digit character and zero padding bits.
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[31:27] == 5'd0
            && ((w_char >= 8'h30 && w_char <= 8'h39) || (w_char >= 8'h41 && w_char <= 8'h46)))
        else $error("output cell is not a digit");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind number_to_text_cell_renderer_top nttcr_checker u_nttcr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
